[rtl/clws_pkg.sv]
// ----------------------------------------------------------------------------
// clws_pkg
// shared types, codes and constants of the character lcd write sequencer
// ----------------------------------------------------------------------------
package clws_pkg;

    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TICK_W;
    localparam int BIDX_W  = 3;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CMD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd2;

    localparam logic              BUS_MODE_RST = 1'b1;
    localparam logic [TICK_W-1:0] PULSE_RST    = 20'd16000;
    localparam logic [TICK_W-1:0] SETTLE_RST   = 20'd160000;

    localparam logic [BIDX_W-1:0] INIT8_LEN = 3'd5;
    localparam logic [BIDX_W-1:0] INIT4_LEN = 3'd7;
    localparam logic [BYTE_W-1:0] HI_NIB_MASK = 8'hF0;

    // power-up command list, selected by bus mode
    function automatic logic [BYTE_W-1:0] init_byte(input logic nib_mode,
                                                    input logic [BIDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        b = 8'h00;
        if (nib_mode) begin
            case (idx)
                3'd0: b = 8'h33;
                3'd1: b = 8'h32;
                3'd2: b = 8'h28;
                3'd3: b = 8'h0C;
                3'd4: b = 8'h01;
                3'd5: b = 8'h06;
                3'd6: b = 8'h02;
                default: b = 8'h00;
            endcase
        end else begin
            case (idx)
                3'd0: b = 8'h38;
                3'd1: b = 8'h0C;
                3'd2: b = 8'h01;
                3'd3: b = 8'h06;
                3'd4: b = 8'h02;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    typedef struct packed {
        logic start;   // latch request, clear event counters
        logic step;    // load next event into output register
    } t_cmd;

    typedef struct packed {
        logic last_evt;  // current event is the final one of the request
        logic out_free;  // output register can take an event this cycle
    } t_status;

endpackage

[rtl/char_lcd_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// expands lcd write requests into timed pin events
// ----------------------------------------------------------------------------
// A request (command byte, character byte or power-up sequence) is expanded
// into pin events, one event per clock while the output side does not stall.
// Each byte gives one enable-high/enable-low strobe pair in 8-bit mode, two
// pairs (high then low nibble on data_bus[7:4]) in 4-bit mode, so a byte
// request gives 2 or 4 events and power-up gives 10 (8-bit) or 28 (4-bit)
// events. The event counter in the datapath emits one event per cycle
// while the output side does not stall; the next request is taken once the
// final event is in the output register. Kind 3 is dropped with no events.
// A timing register of zero is sent as a hold of 1 tick.
// Configuration is read live, so write it only while the block is idle.
module char_lcd_write_sequencer import clws_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [BYTE_W-1:0]     i_value,
    // event channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_reg_select,
    output logic [BYTE_W-1:0]     o_data_bus,
    output logic                  o_enable,
    output logic [TICK_W-1:0]     o_hold_ticks,
    output logic                  o_last
);

    t_cmd    w_cmd;
    t_status w_status;

    // controller: idle/run, decides when a request transfer starts and
    // when the next event moves into the output register
    clws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // datapath: config registers, counters, command tables, output register
    clws_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_reg_select (o_reg_select),
        .o_data_bus   (o_data_bus),
        .o_enable     (o_enable),
        .o_hold_ticks (o_hold_ticks),
        .o_last       (o_last)
    );

endmodule

[rtl/clws_ctrl.sv]
// ----------------------------------------------------------------------------
// clws_ctrl
// request controller: accepts a request and steps the event datapath
// ----------------------------------------------------------------------------
module clws_ctrl import clws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [KIND_W-1:0] i_kind,
    input  t_status           i_status,
    output logic              o_in_stall,
    output t_cmd              o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd.start = w_accept && (i_kind != KIND_UNUSED);
        o_cmd.step  = (r_state == ST_RUN) && i_status.out_free;
        n_state     = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (o_cmd.step && i_status.last_evt) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/clws_datapath.sv]
// ----------------------------------------------------------------------------
// clws_datapath
// config registers, byte/nibble/phase counters and the event output register
// ----------------------------------------------------------------------------
module clws_datapath import clws_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [BYTE_W-1:0]     i_value,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_reg_select,
    output logic [BYTE_W-1:0]     o_data_bus,
    output logic                  o_enable,
    output logic [TICK_W-1:0]     o_hold_ticks,
    output logic                  o_last
);

    logic              r_bus_mode;
    logic [TICK_W-1:0] r_pulse;
    logic [TICK_W-1:0] r_settle;

    logic              r_init;
    logic              r_rs;
    logic [BYTE_W-1:0] r_value;
    logic [BIDX_W-1:0] r_bidx;
    logic              r_nib;
    logic              r_phase;

    logic              r_out_valid;
    logic              r_out_rs;
    logic [BYTE_W-1:0] r_out_bus;
    logic              r_out_en;
    logic [TICK_W-1:0] r_out_hold;
    logic              r_out_last;

    logic [BYTE_W-1:0] w_byte;
    logic [BYTE_W-1:0] w_bus;
    logic [BIDX_W-1:0] w_last_bidx;
    logic [TICK_W-1:0] w_hold;
    logic              w_byte_done;

    always_comb begin
        w_byte      = r_init ? init_byte(r_bus_mode, r_bidx) : r_value;
        if (r_bus_mode) begin
            w_bus = r_nib ? {w_byte[3:0], 4'b0000} : (w_byte & HI_NIB_MASK);
        end else begin
            w_bus = w_byte;
        end
        w_last_bidx = r_init ? ((r_bus_mode ? INIT4_LEN : INIT8_LEN) - 3'd1) : 3'd0;
        w_hold      = r_phase ? r_settle : r_pulse;
        if (w_hold == '0) w_hold = {{(TICK_W-1){1'b0}}, 1'b1};
        w_byte_done = r_phase && (!r_bus_mode || r_nib);
        o_status.last_evt = w_byte_done && (r_bidx == w_last_bidx);
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_mode <= BUS_MODE_RST;
            r_pulse    <= PULSE_RST;
            r_settle   <= SETTLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUS_MODE: r_bus_mode <= i_cfg_data[0];
                CFG_PULSE:    r_pulse    <= i_cfg_data;
                CFG_SETTLE:   r_settle   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request latch and event counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_init  <= (i_kind == KIND_INIT);
            r_rs    <= (i_kind == KIND_CHAR);
            r_value <= i_value;
            r_bidx  <= '0;
            r_nib   <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_cmd.step) begin
            r_phase <= !r_phase;
            if (r_phase) begin
                if (w_byte_done) begin
                    r_nib  <= 1'b0;
                    r_bidx <= r_bidx + 3'd1;
                end else begin
                    r_nib  <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_rs   <= r_rs;
            r_out_bus  <= w_bus;
            r_out_en   <= !r_phase;
            r_out_hold <= w_hold;
            r_out_last <= o_status.last_evt;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_out_rs;
    assign o_data_bus   = r_out_bus;
    assign o_enable     = r_out_en;
    assign o_hold_ticks = r_out_hold;
    assign o_last       = r_out_last;

endmodule

[rtl/clws_checker.sv]
// ----------------------------------------------------------------------------
// clws_checker
// port-level checks of the lcd write sequencer
// ----------------------------------------------------------------------------
module clws_checker import clws_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [KIND_W-1:0] i_kind,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_enable,
    input logic [TICK_W-1:0] o_hold_ticks,
    input logic              o_last
);

    // a stalled event stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("event dropped while stalled");

    // a real request blocks the next one until its events are out
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_kind != KIND_UNUSED) |=> o_in_stall)
        else $error("request not held busy");

    // every strobe ends with enable low, so an enable-high event is never last
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_enable |-> !o_last)
        else $error("enable-high event marked last");

    // hold time is never zero
    a_hold_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hold_ticks != '0))
        else $error("zero hold time");

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_kind       (i_kind),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_enable     (o_enable),
    .o_hold_ticks (o_hold_ticks),
    .o_last       (o_last)
);
